[design/dmrk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dmrk_pkg
// Types, codes and arithmetic helpers shared by the dual motor ramp blocks.
// ----------------------------------------------------------------------------
package dmrk_pkg;

  typedef logic signed [7:0] pct_t;
  typedef logic signed [16:0] pwm_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_STOP  = 2'd2,
    OP_BRAKE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_BRAKE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_LEFT_GAIN  = 3'd0,
    CFG_RIGHT_GAIN = 3'd1,
    CFG_PWM_PERIOD = 3'd2,
    CFG_RAMP_STEP  = 3'd3,
    CFG_KICK_LEVEL = 3'd4,
    CFG_KICK_TICKS = 3'd5
  } cfg_idx_t;

  localparam logic [8:0]  GAIN_RESET   = 9'd256;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [6:0]  STEP_RESET   = 7'd1;
  localparam logic [6:0]  KICK_LEVEL_RESET = 7'd75;
  localparam logic [15:0] KICK_TICKS_RESET = 16'd15;

  localparam logic [6:0] PCT_FULL = 7'd100;

  // Division by 100 as a multiply by 2^30/100 rounded up, then a right shift.
  // Exact for every product of a 16-bit period and a percentage up to 100.
  localparam int          DIV_SHIFT = 30;
  localparam logic [23:0] DIV_RECIP = 24'd10737419;

  typedef struct packed {
    logic [8:0]  left_scale;
    logic [8:0]  right_scale;
    logic [15:0] pwm_period;
    logic [6:0]  ramp_step;
    logic [6:0]  kick_level;
    logic [15:0] kick_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    pct_t  left_now;
    pct_t  right_now;
  } tick_t;

  typedef struct packed {
    mode_t mode;
    pwm_t  left_pwm;
    pwm_t  right_pwm;
    pct_t  left_now;
    pct_t  right_now;
  } res_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } buf_stat_t;

  function automatic pct_t clamp_pct(input logic signed [9:0] v);
    if (v > 10'sd100) begin
      return 8'sd100;
    end else if (v < -10'sd100) begin
      return -8'sd100;
    end
    return v[7:0];
  endfunction

  function automatic pct_t apply_gain(input pct_t req, input logic [8:0] gain);
    pct_t                c;
    logic signed [17:0]  p;
    logic signed [17:0]  pb;
    c  = clamp_pct({{2{req[7]}}, req});
    p  = $signed({{10{c[7]}}, c}) * $signed({9'b0, gain});
    // Bias negative products so that the shift truncates toward zero.
    pb = p[17] ? p + 18'sd255 : p;
    return clamp_pct(pb[17:8]);
  endfunction

  function automatic pct_t kick_value(input pct_t tgt, input logic [6:0] lvl);
    logic [6:0] l;
    pct_t       ls;
    l  = (lvl > PCT_FULL) ? PCT_FULL : lvl;
    ls = $signed({1'b0, l});
    if (tgt > 8'sd0) begin
      return (tgt > ls) ? tgt : ls;
    end else if (tgt < 8'sd0) begin
      return (tgt < -ls) ? tgt : -ls;
    end
    return 8'sd0;
  endfunction

  function automatic pct_t slew(input pct_t cur, input pct_t tgt, input logic [6:0] step);
    logic signed [9:0] c;
    logic signed [9:0] t;
    logic signed [9:0] s;
    logic signed [9:0] u;
    c = {{2{cur[7]}}, cur};
    t = {{2{tgt[7]}}, tgt};
    s = $signed({3'b0, step});
    u = c;
    if (c < t) begin
      u = c + s;
      if (u > t) u = t;
    end else if (c > t) begin
      u = c - s;
      if (u < t) u = t;
    end
    return u[7:0];
  endfunction

endpackage
`default_nettype wire

[design/dual_motor_ramp_with_kick_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_motor_ramp_with_kick_unit
// Two-wheel speed controller with slew limiting and a startup kick.
// ----------------------------------------------------------------------------
// Each input beat is one event (tick, set targets, stop, brake) and is taken
// in every cycle while the output skid entry is empty; only tick beats give
// an output beat. A tick result passes the input register, the state update
// into the tick register, the period multiply and the divide-by-100 multiply
// into the output register; the pipeline stalls while the skid entry is full.
// State updates for one event are registered before the next event
// is applied, so back-to-back events see each other's effect.
// Configuration registers may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module dual_motor_ramp_with_kick_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[1:0], left_request[9:2], right_request[17:10], zero pad [23:18]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // drive_mode[1:0], left_pwm[18:2], right_pwm[35:19], left_now[43:36],
  // right_now[51:44], zero pad [55:52]
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dmrk_pkg::cfg_t      cfg;
  dmrk_pkg::buf_stat_t stat;
  dmrk_pkg::tick_t     tick;
  dmrk_pkg::res_t      res;
  dmrk_pkg::res_t      out_res;
  logic                en;
  logic                tick_valid;
  logic                res_valid;

  assign cfg_ready     = 1'b1;
  assign en            = !stat.skid_full;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_scale  <= dmrk_pkg::GAIN_RESET;
      cfg.right_scale <= dmrk_pkg::GAIN_RESET;
      cfg.pwm_period  <= dmrk_pkg::PERIOD_RESET;
      cfg.ramp_step   <= dmrk_pkg::STEP_RESET;
      cfg.kick_level  <= dmrk_pkg::KICK_LEVEL_RESET;
      cfg.kick_ticks  <= dmrk_pkg::KICK_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dmrk_pkg::CFG_LEFT_GAIN:  cfg.left_scale  <= cfg_data[8:0];
        dmrk_pkg::CFG_RIGHT_GAIN: cfg.right_scale <= cfg_data[8:0];
        dmrk_pkg::CFG_PWM_PERIOD: cfg.pwm_period  <= cfg_data;
        dmrk_pkg::CFG_RAMP_STEP:  cfg.ramp_step   <= cfg_data[6:0];
        dmrk_pkg::CFG_KICK_LEVEL: cfg.kick_level  <= cfg_data[6:0];
        dmrk_pkg::CFG_KICK_TICKS: cfg.kick_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dmrk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_axis_tvalid),
    .in_op      (s_axis_tdata[1:0]),
    .in_left    (s_axis_tdata[9:2]),
    .in_right   (s_axis_tdata[17:10]),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  dmrk_pwm u_pwm (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .tick_valid (tick_valid),
    .tick       (tick),
    .period     (cfg.pwm_period),
    .res_valid  (res_valid),
    .res        (res)
  );

  dmrk_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .stat      (stat)
  );

  assign m_axis_tdata = {4'b0, out_res.right_now, out_res.left_now, out_res.right_pwm,
                         out_res.left_pwm, out_res.mode};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    stat.skid_full |-> stat.out_full)
    else $error("skid entry holds a result while the output register is empty");

  a_stop_zero_pwm: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.mode == dmrk_pkg::MODE_STOP) |->
      (out_res.left_pwm == 17'sd0 && out_res.right_pwm == 17'sd0 &&
       out_res.left_now == 8'sd0 && out_res.right_now == 8'sd0))
    else $error("stopped result carries a nonzero speed");

  a_brake_zero_now: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.mode == dmrk_pkg::MODE_BRAKE) |->
      (out_res.left_now == 8'sd0 && out_res.right_now == 8'sd0 &&
       out_res.left_pwm == out_res.right_pwm))
    else $error("brake result with moving wheels or unequal compare values");

endmodule
`default_nettype wire

[design/dmrk_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dmrk_ctrl
// Input register and the speed state machine: targets, currents, run mode
// and kick counter. Emits one tick record per tick beat.
// ----------------------------------------------------------------------------
module dmrk_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_op,
  input  wire dmrk_pkg::pct_t  in_left,
  input  wire dmrk_pkg::pct_t  in_right,
  input  wire dmrk_pkg::cfg_t  cfg,
  output logic                 tick_valid,
  output dmrk_pkg::tick_t      tick
);

  logic            cmd_valid;
  dmrk_pkg::op_t   cmd_op;
  dmrk_pkg::pct_t  cmd_left;
  dmrk_pkg::pct_t  cmd_right;

  dmrk_pkg::pct_t  left_target, left_target_next;
  dmrk_pkg::pct_t  right_target, right_target_next;
  dmrk_pkg::pct_t  left_current, left_current_next;
  dmrk_pkg::pct_t  right_current, right_current_next;
  dmrk_pkg::mode_t run_mode, run_mode_next;
  logic [15:0]     kick_left, kick_left_next;
  logic            tick_valid_next;

  dmrk_pkg::pct_t  set_left, set_right;
  dmrk_pkg::pct_t  slew_left, slew_right;

  always_comb begin
    set_left   = dmrk_pkg::apply_gain(cmd_left, cfg.left_scale);
    set_right  = dmrk_pkg::apply_gain(cmd_right, cfg.right_scale);
    slew_left  = dmrk_pkg::slew(left_current, left_target, cfg.ramp_step);
    slew_right = dmrk_pkg::slew(right_current, right_target, cfg.ramp_step);

    left_target_next   = left_target;
    right_target_next  = right_target;
    left_current_next  = left_current;
    right_current_next = right_current;
    run_mode_next      = run_mode;
    kick_left_next     = kick_left;
    tick_valid_next    = 1'b0;

    if (cmd_valid) begin
      case (cmd_op)
        dmrk_pkg::OP_SET: begin
          if (left_target == 8'sd0 && right_target == 8'sd0 &&
              (set_left != 8'sd0 || set_right != 8'sd0) &&
              run_mode != dmrk_pkg::MODE_BRAKE) begin
            kick_left_next = cfg.kick_ticks;
          end
          left_target_next  = set_left;
          right_target_next = set_right;
        end
        dmrk_pkg::OP_STOP: begin
          left_target_next  = 8'sd0;
          right_target_next = 8'sd0;
          kick_left_next    = 16'd0;
          if (run_mode == dmrk_pkg::MODE_BRAKE) begin
            run_mode_next = dmrk_pkg::MODE_STOP;
          end
        end
        dmrk_pkg::OP_BRAKE: begin
          run_mode_next      = dmrk_pkg::MODE_BRAKE;
          left_target_next   = 8'sd0;
          right_target_next  = 8'sd0;
          left_current_next  = 8'sd0;
          right_current_next = 8'sd0;
          kick_left_next     = 16'd0;
        end
        dmrk_pkg::OP_TICK: begin
          tick_valid_next = 1'b1;
          if (run_mode == dmrk_pkg::MODE_BRAKE) begin
            left_current_next  = 8'sd0;
            right_current_next = 8'sd0;
          end else if (kick_left != 16'd0) begin
            left_current_next  = dmrk_pkg::kick_value(left_target, cfg.kick_level);
            right_current_next = dmrk_pkg::kick_value(right_target, cfg.kick_level);
            kick_left_next     = kick_left - 16'd1;
            run_mode_next      = dmrk_pkg::MODE_RUN;
          end else begin
            left_current_next  = slew_left;
            right_current_next = slew_right;
            if (slew_left == 8'sd0 && slew_right == 8'sd0 &&
                left_target == 8'sd0 && right_target == 8'sd0) begin
              run_mode_next = dmrk_pkg::MODE_STOP;
            end else begin
              run_mode_next = dmrk_pkg::MODE_RUN;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid     <= 1'b0;
      left_target   <= 8'sd0;
      right_target  <= 8'sd0;
      left_current  <= 8'sd0;
      right_current <= 8'sd0;
      run_mode      <= dmrk_pkg::MODE_STOP;
      kick_left     <= 16'd0;
      tick_valid    <= 1'b0;
    end else if (en) begin
      cmd_valid     <= in_valid;
      left_target   <= left_target_next;
      right_target  <= right_target_next;
      left_current  <= left_current_next;
      right_current <= right_current_next;
      run_mode      <= run_mode_next;
      kick_left     <= kick_left_next;
      tick_valid    <= tick_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_op          <= dmrk_pkg::op_t'(in_op);
      cmd_left        <= in_left;
      cmd_right       <= in_right;
      tick.mode       <= run_mode_next;
      tick.left_now   <= left_current_next;
      tick.right_now  <= right_current_next;
    end
  end

endmodule
`default_nettype wire

[design/dmrk_pwm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dmrk_pwm
// Converts a tick record into signed compare values: a period multiply stage
// followed by a reciprocal multiply that divides by one hundred.
// ----------------------------------------------------------------------------
module dmrk_pwm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            tick_valid,
  input  wire dmrk_pkg::tick_t tick,
  input  wire logic [15:0]     period,
  output logic                 res_valid,
  output dmrk_pkg::res_t       res
);

  logic [6:0]      mag_left, mag_right;
  logic            prod_valid;
  dmrk_pkg::tick_t prod_tick;
  logic [22:0]     prod_left, prod_right;
  logic [46:0]     scaled_left, scaled_right;
  logic [16:0]     quot_left, quot_right;
  dmrk_pkg::pwm_t  pwm_left, pwm_right;

  always_comb begin
    mag_left  = tick.left_now[7]  ? 7'(-tick.left_now)  : tick.left_now[6:0];
    mag_right = tick.right_now[7] ? 7'(-tick.right_now) : tick.right_now[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_tick  <= tick;
      prod_left  <= 23'(period) * 23'(mag_left);
      prod_right <= 23'(period) * 23'(mag_right);
    end
  end

  always_comb begin
    scaled_left  = 47'(prod_left) * 47'(dmrk_pkg::DIV_RECIP);
    scaled_right = 47'(prod_right) * 47'(dmrk_pkg::DIV_RECIP);
    quot_left    = scaled_left[46:dmrk_pkg::DIV_SHIFT];
    quot_right   = scaled_right[46:dmrk_pkg::DIV_SHIFT];
    pwm_left     = prod_tick.left_now[7]  ? -$signed(quot_left)  : $signed(quot_left);
    pwm_right    = prod_tick.right_now[7] ? -$signed(quot_right) : $signed(quot_right);

    res.mode      = prod_tick.mode;
    res.left_now  = prod_tick.left_now;
    res.right_now = prod_tick.right_now;
    case (prod_tick.mode)
      dmrk_pkg::MODE_BRAKE: begin
        res.left_pwm  = $signed({1'b0, period});
        res.right_pwm = $signed({1'b0, period});
      end
      dmrk_pkg::MODE_RUN: begin
        res.left_pwm  = pwm_left;
        res.right_pwm = pwm_right;
      end
      default: begin
        res.left_pwm  = 17'sd0;
        res.right_pwm = 17'sd0;
      end
    endcase
    res_valid = prod_valid;
  end

endmodule
`default_nettype wire

[design/dmrk_outbuf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dmrk_outbuf
// Output register with one skid entry. The pipeline behind it advances only
// while the skid entry is empty, so no result is ever dropped.
// ----------------------------------------------------------------------------
module dmrk_outbuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire dmrk_pkg::res_t in_res,
  input  wire logic           out_ready,
  output logic                out_valid,
  output dmrk_pkg::res_t      out_res,
  output dmrk_pkg::buf_stat_t stat
);

  logic           skid_valid;
  dmrk_pkg::res_t skid_res;
  logic           take;
  logic           arrive;

  assign take   = out_valid && out_ready;
  assign arrive = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= arrive;
      out_res   <= in_res;
    end else if (arrive) begin
      skid_valid <= 1'b1;
      skid_res   <= in_res;
    end
  end

  assign stat.out_full  = out_valid;
  assign stat.skid_full = skid_valid;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual motor ramp with startup kick.
// ----------------------------------------------------------------------------
// A short table of events is sent first. Its rows after reset, at the extremes,
// after a stop, in a kick and in brake carry their expected tick beat typed
// in, and the other rows are checked against a behavioural model of both
// wheels held in the bench. Then several register settings follow, each with
// a run of random events. A run is mostly targets followed by ticks, with
// stops and brakes mixed in. Both stream sides idle in random bursts, except
// in the final setting. Every tick beat that leaves the block is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import dmrk_pkg::*;

  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 22;
  localparam int N_PER_PHASE = 111;
  localparam int N_PHASES    = 7;

  typedef struct packed {
    mode_t mode;
    pwm_t  left_pwm;
    pwm_t  right_pwm;
    pct_t  left_now;
    pct_t  right_now;
  } tick_beat_t;

  typedef struct packed {
    op_t        op;
    pct_t       left_req;
    pct_t       right_req;
    logic       pinned;
    tick_beat_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dual_motor_ramp_with_kick_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Register mirror.
  logic [8:0]  lgain_r;
  logic [8:0]  rgain_r;
  logic [15:0] period_r;
  logic [6:0]  step_r;
  logic [6:0]  klevel_r;
  logic [15:0] kticks_r;

  // Wheel state.
  int    tgt_l;
  int    tgt_r;
  int    cur_l;
  int    cur_r;
  int    kick_cnt;
  mode_t run_state;

  tick_beat_t pending_ticks[$];
  stim_row_t  dir_rows[0:N_DIRECTED-1];

  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit feed_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  function automatic int clip100(input int v);
    if (v > 100) return 100;
    if (v < -100) return -100;
    return v;
  endfunction

  function automatic int scaled_target(input int req, input int gain);
    return clip100((clip100(req) * gain) / 256);
  endfunction

  function automatic int kick_floor(input int tgt, input int lvl);
    if (tgt > 0) return (tgt > lvl) ? tgt : lvl;
    if (tgt < 0) return (tgt < -lvl) ? tgt : -lvl;
    return 0;
  endfunction

  function automatic int slew_to(input int cur, input int tgt, input int step);
    int c;
    c = cur;
    if (c < tgt) begin
      c = c + step;
      if (c > tgt) c = tgt;
    end else if (c > tgt) begin
      c = c - step;
      if (c < tgt) c = tgt;
    end
    return c;
  endfunction

  function automatic int duty_count(input int pct);
    return (int'(period_r) * clip100(pct)) / 100;
  endfunction

  function automatic void step_controller(input op_t op, input pct_t lreq, input pct_t rreq,
                                          output bit ticked, output tick_beat_t beat);
    int nl;
    int nr;
    int lvl;
    int lp;
    int rp;
    ticked = 1'b0;
    beat   = '0;
    case (op)
      OP_SET: begin
        nl = scaled_target(int'(lreq), int'(lgain_r));
        nr = scaled_target(int'(rreq), int'(rgain_r));
        if (tgt_l == 0 && tgt_r == 0 && (nl != 0 || nr != 0) && run_state != MODE_BRAKE)
          kick_cnt = int'(kticks_r);
        tgt_l = nl;
        tgt_r = nr;
      end
      OP_STOP: begin
        tgt_l    = 0;
        tgt_r    = 0;
        kick_cnt = 0;
        if (run_state == MODE_BRAKE) run_state = MODE_STOP;
      end
      OP_BRAKE: begin
        run_state = MODE_BRAKE;
        tgt_l     = 0;
        tgt_r     = 0;
        cur_l     = 0;
        cur_r     = 0;
        kick_cnt  = 0;
      end
      OP_TICK: begin
        if (run_state == MODE_BRAKE) begin
          cur_l = 0;
          cur_r = 0;
        end else if (kick_cnt > 0) begin
          lvl       = (klevel_r > 7'd100) ? 100 : int'(klevel_r);
          cur_l     = kick_floor(tgt_l, lvl);
          cur_r     = kick_floor(tgt_r, lvl);
          kick_cnt  = kick_cnt - 1;
          run_state = MODE_RUN;
        end else begin
          cur_l = slew_to(cur_l, tgt_l, int'(step_r));
          cur_r = slew_to(cur_r, tgt_r, int'(step_r));
          if (cur_l == 0 && cur_r == 0 && tgt_l == 0 && tgt_r == 0)
            run_state = MODE_STOP;
          else
            run_state = MODE_RUN;
        end
        if (run_state == MODE_BRAKE) begin
          lp = int'(period_r);
          rp = int'(period_r);
        end else if (run_state == MODE_STOP) begin
          lp = 0;
          rp = 0;
        end else begin
          lp = duty_count(cur_l);
          rp = duty_count(cur_r);
        end
        ticked          = 1'b1;
        beat.mode       = run_state;
        beat.left_pwm   = pwm_t'(lp);
        beat.right_pwm  = pwm_t'(rp);
        beat.left_now   = pct_t'(cur_l);
        beat.right_now  = pct_t'(cur_r);
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t row(input op_t op, input int l, input int r);
    stim_row_t s;
    s           = '0;
    s.op        = op;
    s.left_req  = pct_t'(l);
    s.right_req = pct_t'(r);
    return s;
  endfunction

  function automatic stim_row_t pinned(input op_t op, input mode_t m, input int lp,
                                       input int rp, input int ln, input int rn);
    stim_row_t s;
    s                = row(op, 0, 0);
    s.pinned         = 1'b1;
    s.want.mode      = m;
    s.want.left_pwm  = pwm_t'(lp);
    s.want.right_pwm = pwm_t'(rp);
    s.want.left_now  = pct_t'(ln);
    s.want.right_now = pct_t'(rn);
    return s;
  endfunction

  function automatic pct_t random_request();
    pct_t v;
    case ($urandom_range(0, 9))
      0: v = 8'sd0;
      1: v = 8'sh80;
      2: v = 8'sd127;
      3: v = 8'sd100;
      4: v = -8'sd100;
      5: v = pct_t'(int'($urandom_range(0, 10)) - 5);
      default: v = pct_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic compare_beat(input tick_beat_t exp, input tick_beat_t got);
    if (exp.mode !== got.mode) begin
      $display("%0t: drive_mode expected %0d got %0d", $time, exp.mode, got.mode);
      errors++;
    end
    if (exp.left_pwm !== got.left_pwm) begin
      $display("%0t: left_pwm expected %0d got %0d", $time, exp.left_pwm, got.left_pwm);
      errors++;
    end
    if (exp.right_pwm !== got.right_pwm) begin
      $display("%0t: right_pwm expected %0d got %0d", $time, exp.right_pwm, got.right_pwm);
      errors++;
    end
    if (exp.left_now !== got.left_now) begin
      $display("%0t: left_now expected %0d got %0d", $time, exp.left_now, got.left_now);
      errors++;
    end
    if (exp.right_now !== got.right_now) begin
      $display("%0t: right_now expected %0d got %0d", $time, exp.right_now, got.right_now);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    tick_beat_t got;
    tick_beat_t exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.mode      = mode_t'(m_axis_tdata[1:0]);
      got.left_pwm  = m_axis_tdata[18:2];
      got.right_pwm = m_axis_tdata[35:19];
      got.left_now  = m_axis_tdata[43:36];
      got.right_now = m_axis_tdata[51:44];
      if (pending_ticks.size() == 0) begin
        $display("%0t: beat expected none got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp = pending_ticks.pop_front();
        compare_beat(exp, got);
      end
    end
  end

  always @(negedge clk) begin
    if (!sink_stalls) begin
      stall_left = 0;
    end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called and returning at a falling edge.
  task automatic send_event(input op_t op, input pct_t lreq, input pct_t rreq,
                            input logic pin, input tick_beat_t want);
    bit         ticked;
    tick_beat_t beat;
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rreq, lreq, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    step_controller(op, lreq, rreq, ticked, beat);
    if (ticked) pending_ticks.push_back(pin ? want : beat);
    @(negedge clk);
  endtask

  task automatic drain_ticks(input int extra);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_ticks.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEFT_GAIN:  lgain_r  = val[8:0];
      CFG_RIGHT_GAIN: rgain_r  = val[8:0];
      CFG_PWM_PERIOD: period_r = val;
      CFG_RAMP_STEP:  step_r   = val[6:0];
      CFG_KICK_LEVEL: klevel_r = val[6:0];
      CFG_KICK_TICKS: kticks_r = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input int lg, input int rg, input int per, input int st,
                           input int lvl, input int kt);
    write_reg(CFG_LEFT_GAIN, 16'(lg));
    write_reg(CFG_RIGHT_GAIN, 16'(rg));
    write_reg(CFG_PWM_PERIOD, 16'(per));
    write_reg(CFG_RAMP_STEP, 16'(st));
    write_reg(CFG_KICK_LEVEL, 16'(lvl));
    write_reg(CFG_KICK_TICKS, 16'(kt));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit idle_ok);
    int   k;
    op_t  op;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        feed_gaps   = idle_ok && ($urandom_range(0, 2) != 0);
        sink_stalls = idle_ok && ($urandom_range(0, 2) != 0);
      end
      if (idle_ok && i == count / 2) drain_ticks(0);
      k = $urandom_range(0, 99);
      if (k < 58)      op = OP_TICK;
      else if (k < 80) op = OP_SET;
      else if (k < 92) op = OP_STOP;
      else             op = OP_BRAKE;
      send_event(op, random_request(), random_request(), 1'b0, '0);
    end
  endtask

  initial begin
    lgain_r   = GAIN_RESET;
    rgain_r   = GAIN_RESET;
    period_r  = PERIOD_RESET;
    step_r    = STEP_RESET;
    klevel_r  = KICK_LEVEL_RESET;
    kticks_r  = KICK_TICKS_RESET;
    tgt_l     = 0;
    tgt_r     = 0;
    cur_l     = 0;
    cur_r     = 0;
    kick_cnt  = 0;
    run_state = MODE_STOP;

    dir_rows = '{
      pinned(OP_TICK, MODE_STOP, 0, 0, 0, 0),
      row(OP_SET, 127, -128),
      pinned(OP_TICK, MODE_RUN, 1000, -1000, 100, -100),
      row(OP_TICK, 0, 0),
      row(OP_SET, 0, 0),
      row(OP_TICK, 0, 0),
      row(OP_STOP, 0, 0),
      pinned(OP_TICK, MODE_STOP, 0, 0, 0, 0),
      row(OP_SET, -1, 1),
      pinned(OP_TICK, MODE_RUN, -750, 750, -75, 75),
      row(OP_TICK, 0, 0),
      row(OP_BRAKE, 0, 0),
      pinned(OP_TICK, MODE_BRAKE, 1000, 1000, 0, 0),
      row(OP_SET, 50, -50),
      pinned(OP_TICK, MODE_BRAKE, 1000, 1000, 0, 0),
      row(OP_STOP, 0, 0),
      row(OP_TICK, 0, 0),
      row(OP_SET, 100, -100),
      row(OP_TICK, 0, 0),
      row(OP_SET, 2, -3),
      row(OP_TICK, 0, 0),
      row(OP_BRAKE, -128, 127)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    feed_gaps   = 1'b1;
    sink_stalls = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++)
      send_event(dir_rows[i].op, dir_rows[i].left_req, dir_rows[i].right_req,
                 dir_rows[i].pinned, dir_rows[i].want);
    drain_ticks(SETTLE);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: configure(128, 384, 65535, 100, 100, 65535);
        1: configure(384, 128, 1, 1, 0, 0);
        2: configure(0, 511, 0, 0, 127, 2);
        3, 4: configure($urandom_range(128, 384), $urandom_range(128, 384),
                        $urandom_range(1, 65535), $urandom_range(1, 100),
                        $urandom_range(0, 100), $urandom_range(0, 20));
        5: configure($urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 65535), $urandom_range(0, 127),
                     $urandom_range(0, 127), $urandom_range(0, 40));
        default: configure(256, 256, 1000, 1, 75, 15);
      endcase
      run_random(N_PER_PHASE, p != N_PHASES - 1);
      drain_ticks(SETTLE);
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
design/dmrk_pkg.sv
design/dmrk_ctrl.sv
design/dmrk_pwm.sv
design/dmrk_outbuf.sv
design/dual_motor_ramp_with_kick_unit.sv
tb/sv/tb_top.sv
